// ===== sv/radix_digit_converter_defines.svh =====
// assertion macros for the radix digit converter
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// plain property, checked out of reset on the block clock
`define RDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// same-cycle implication
`define RDC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);
`else
`define RDC_ASSERT(lbl, prop, msg)
`define RDC_ASSERT_IMPL(lbl, ante, cons, msg)
`define RDC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/rdc_pkg.sv =====
// constants and helpers for the radix digit converter
package rdc_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned COUNT_W     = 6;
    localparam int unsigned STORE_DEPTH = 32;
    localparam int unsigned STORE_AW    = 5;
    localparam int unsigned QBITS       = 4;  // quotient bits resolved per cycle

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h41;
    localparam logic [DIGIT_W-1:0] DEC_LIMIT   = 4'd10;

    // register index, taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    function automatic char_t digit_to_ascii(input digit_t d);
        char_t c;
        if (d < DEC_LIMIT) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A + CHAR_W'(d - DEC_LIMIT);
        end
        return c;
    endfunction

endpackage

// ===== sv/radix_digit_converter.sv =====
// radix digit converter: each digit comes from one long division of the value (4 quotient bits a
// cycle on a 5-bit compare and subtract chain); every digit is then read out through the registered
// digit store.
// an error item (bad radix or zero value) gives its one result in the cycle after accept.
// one item at a time: s_tready is high only while idle.
// aresetn is synchronous, active low: clears control, output valid, digit count, radix to 10.
`include "radix_digit_converter_defines.svh"

module radix_digit_converter #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input item
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    // result item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] digit_char, [7] zero
    output logic        m_tlast,   // is_last
    output logic [0:0]  m_tuser,   // [0] invalid
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned VW     = (VALUE_BITS < rdc_pkg::VALUE_W) ? VALUE_BITS
                                                                      : rdc_pkg::VALUE_W;
    localparam int unsigned NSTEP  = (VW + rdc_pkg::QBITS - 1) / rdc_pkg::QBITS;
    localparam int unsigned PW     = NSTEP * rdc_pkg::QBITS;
    localparam int unsigned STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [rdc_pkg::RADIX_W-1:0]      radix_reg;
    logic [PW-1:0]                    div_reg, div_next, div_shift;
    logic [rdc_pkg::DIGIT_W-1:0]      rem_reg, rem_next, rem_step;
    logic [STEP_W-1:0]                step_reg, step_next;
    logic [rdc_pkg::COUNT_W-1:0]      digit_count_reg, digit_count_next;
    logic [rdc_pkg::STORE_AW-1:0]     idx_reg, idx_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    rdc_pkg::char_t                   out_char_reg, out_char_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_inv_reg, out_inv_next;
    rdc_pkg::digit_t                  rd_data_reg;
    rdc_pkg::digit_t                  digit_store [rdc_pkg::STORE_DEPTH];
    logic                             store_wr;
    logic [rdc_pkg::QBITS-1:0]        qbits;
    logic [rdc_pkg::DIGIT_W:0]        trial;
    logic [VW-1:0]                    in_value;
    logic                             radix_bad;
    logic                             cfg_wr;

    assign in_value  = s_tdata[VW-1:0];
    assign radix_bad = (radix_reg < rdc_pkg::RADIX_MIN) || (radix_reg > rdc_pkg::RADIX_MAX);
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == rdc_pkg::REG_RADIX);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rdc_pkg::REG_RADIX) ? 32'(radix_reg) : 32'd0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_inv_reg;

    // shared divider slice: QBITS restoring steps on a narrow remainder
    always_comb begin
        rem_step = rem_reg;
        qbits    = '0;
        trial    = '0;
        for (int j = 0; j < int'(rdc_pkg::QBITS); j++) begin
            trial = {rem_step, div_reg[PW-1-j]};
            if (trial >= {1'b0, radix_reg}) begin
                rem_step                         = rdc_pkg::DIGIT_W'(trial - {1'b0, radix_reg});
                qbits[rdc_pkg::QBITS-1-j]        = 1'b1;
            end else begin
                rem_step = trial[rdc_pkg::DIGIT_W-1:0];
            end
        end
        div_shift = {div_reg[PW-rdc_pkg::QBITS-1:0], qbits};
    end

    always_comb begin
        state_next       = state_reg;
        div_next         = div_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        digit_count_next = digit_count_reg;
        idx_next         = idx_reg;
        m_tvalid_next    = m_tvalid_reg;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;
        out_inv_next     = out_inv_reg;
        store_wr         = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (radix_bad || (in_value == '0)) begin
                        digit_count_next = '0;
                        out_char_next    = '0;
                        out_last_next    = 1'b1;
                        out_inv_next     = 1'b1;
                        m_tvalid_next    = 1'b1;
                        state_next       = S_OUT;
                    end else begin
                        digit_count_next = '0;
                        div_next         = PW'(in_value);
                        rem_next         = '0;
                        step_next        = '0;
                        state_next       = S_DIV;
                    end
                end
            end
            S_DIV: begin
                div_next  = div_shift;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NSTEP - 1)) begin
                    // digit done: remainder goes to the store, quotient is the next dividend
                    store_wr         = 1'b1;
                    digit_count_next = digit_count_reg + 1'b1;
                    rem_next         = '0;
                    step_next        = '0;
                    if (div_shift == '0) begin
                        idx_next   = digit_count_reg[rdc_pkg::STORE_AW-1:0];
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                out_char_next = rdc_pkg::digit_to_ascii(rd_data_reg);
                out_last_next = (idx_reg == '0);
                out_inv_next  = 1'b0;
                m_tvalid_next = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (out_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            radix_reg       <= rdc_pkg::RADIX_RESET;
            digit_count_reg <= '0;
            step_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            step_reg        <= step_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_wr) begin
                radix_reg <= pwdata[rdc_pkg::RADIX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        idx_reg      <= idx_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_inv_reg  <= out_inv_next;
    end

    // digit store, least significant digit at address zero
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            digit_store[digit_count_reg[rdc_pkg::STORE_AW-1:0]] <= rem_step;
        end
        rd_data_reg <= digit_store[idx_reg];
    end

    `RDC_ASSERT_IMPL(a_inv_is_last, m_tvalid && m_tuser[0], m_tlast && (m_tdata == 8'd0),
        "invalid item must be a single last item with zero data")
    `RDC_ASSERT_IMPL(a_digit_ascii, m_tvalid && !m_tuser[0],
        ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)) || ((m_tdata >= 8'h41) && (m_tdata <= 8'h46)),
        "digit item outside 0-9 and A-F")
    `RDC_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input taken while a result is pending")
    `RDC_ASSERT(a_count_range, digit_count_reg <= rdc_pkg::COUNT_W'(rdc_pkg::STORE_DEPTH),
        "digit count beyond store depth")
    `RDC_ASSERT_NEXT(a_gap_after_digit, m_tvalid && m_tready && !m_tlast, !m_tvalid && !s_tready,
        "next digit must come from a store fetch")

endmodule

// ===== verif/radix_digit_checker.sv =====
// checker for the radix digit converter: predicts digits and compares every result item
`timescale 1ns / 1ps

module radix_digit_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [6:0] digit_char, [7] zero
    input  logic        m_tlast,   // is_last
    input  logic [0:0]  m_tuser,   // [0] invalid
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        rdc_pkg::char_t ch;
        logic           last;
        logic           bad;
    } digit_res_t;

    digit_res_t                  digits_due[$];
    logic [rdc_pkg::RADIX_W-1:0] base_q;

    // splits one value into its digits in the given base, most significant first
    function automatic void predict_digits(input logic [31:0] v,
                                           input logic [rdc_pkg::RADIX_W-1:0] base);
        logic [31:0]     rest;
        rdc_pkg::digit_t digs[rdc_pkg::STORE_DEPTH];
        int              n;
        digit_res_t      r;
        if (base < rdc_pkg::RADIX_MIN || base > rdc_pkg::RADIX_MAX || v == 32'd0) begin
            r.ch   = '0;
            r.last = 1'b1;
            r.bad  = 1'b1;
            digits_due.push_back(r);
            return;
        end
        rest = v;
        n = 0;
        while (rest != 32'd0) begin
            digs[n] = rdc_pkg::digit_t'(rest % base);
            rest = rest / base;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            if (digs[k] < rdc_pkg::DEC_LIMIT) begin
                r.ch = rdc_pkg::CHAR_ZERO + rdc_pkg::char_t'(digs[k]);
            end else begin
                r.ch = rdc_pkg::CHAR_A + rdc_pkg::char_t'(digs[k] - rdc_pkg::DEC_LIMIT);
            end
            r.last = (k == 0);
            r.bad  = 1'b0;
            digits_due.push_back(r);
        end
    endfunction

    initial begin
        fail_count = 0;
        pending    = 0;
        base_q     = rdc_pkg::RADIX_RESET;
    end

    always @(posedge aclk) begin
        digit_res_t want;
        if (!aresetn) begin
            base_q = rdc_pkg::RADIX_RESET;
            digits_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr[2] == rdc_pkg::REG_RADIX) begin
                base_q = pwdata[rdc_pkg::RADIX_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                if (digits_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result item tdata=%h tlast=%b tuser=%b",
                                 $realtime, m_tdata, m_tlast, m_tuser);
                    end
                end else begin
                    want = digits_due.pop_front();
                    if (m_tdata !== {1'b0, want.ch} || m_tlast !== want.last ||
                        m_tuser[0] !== want.bad) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch tdata/tlast/tuser exp %h/%b/%b got %h/%b/%b",
                                     $realtime, {1'b0, want.ch}, want.last, want.bad,
                                     m_tdata, m_tlast, m_tuser);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_digits(s_tdata, base_q);
            end
        end
        pending = digits_due.size();
    end

endmodule

// ===== verif/radix_digit_converter_tb.sv =====
// testbench top for the radix digit converter: stimulus, handshake pacing and verdict
`timescale 1ns / 1ps

module radix_digit_converter_tb;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam logic [2:0]  ADDR_RADIX  = 3'd0;
    localparam logic [2:0]  ADDR_UNUSED = 3'd4;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_stall;
    int unsigned cycles;

    always #5 aclk = ~aclk;

    radix_digit_converter i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    radix_digit_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // waits until every digit is out and the block takes new items again
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending != 0 || !s_tready);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'd0;
            1:       v = 32'hFFFF_FFFF;
            2, 3:    v = $urandom_range(1, 1000);
            4, 5:    v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    initial begin
        logic [4:0] base;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        send_idle  = 0;
        recv_stall = 0;
        cycles     = 0;
        aresetn    = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset radix is ten
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        drain();
        write_reg(ADDR_RADIX, 32'd16);
        send_value(32'hFEDC_BA98);
        send_value(32'h0123_4567);
        drain();
        // write to an unmapped register must leave the radix alone
        write_reg(ADDR_UNUSED, 32'd3);
        send_value(32'h0000_00FF);
        drain();
        write_reg(ADDR_RADIX, 32'd2);
        send_value(32'hFFFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'h5555_5555);
        drain();
        write_reg(ADDR_RADIX, 32'd3);
        send_value(32'hFFFF_FFFF);
        drain();
        // out of range radix gives the error item for any value
        write_reg(ADDR_RADIX, 32'd0);
        send_value(32'd5);
        drain();
        write_reg(ADDR_RADIX, 32'd1);
        send_value(32'd5);
        drain();
        write_reg(ADDR_RADIX, 32'd17);
        send_value(32'h0001_2345);
        drain();
        write_reg(ADDR_RADIX, 32'hFFFF_FFFF);
        send_value(32'd1);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 62; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 62; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            if (phase == 0) begin
                base = 5'd2;
            end else if (phase == 1) begin
                base = 5'd16;
            end else if ($urandom_range(5) == 0) begin
                base = ($urandom_range(1) == 0) ? 5'($urandom_range(1)) :
                                                  5'($urandom_range(17, 31));
            end else begin
                base = 5'($urandom_range(2, 16));
            end
            // upper bits of the write data are junk that the block ignores
            write_reg(ADDR_RADIX, {3'($urandom_range(7)), 24'd0, base});
            for (int i = 0; i < 30; i++) begin
                send_value(random_value());
            end
            drain();
        end

        repeat (300) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
